// File: rtl/jts_pkg.sv
// Shared types and character constants for the JSON token scanner.
package jts_pkg;

    typedef enum logic [3:0] {
        K_OBJ_BEGIN  = 4'd0,
        K_OBJ_END    = 4'd1,
        K_LIST_BEGIN = 4'd2,
        K_LIST_END   = 4'd3,
        K_INT        = 4'd4,
        K_STR_CHAR   = 4'd5,
        K_STR_END    = 4'd6,
        K_BAD_CHAR   = 4'd7,
        K_OVERFLOW   = 4'd8
    } t_kind;

    // One queue entry: an optional integer flush, then an optional token.
    typedef struct packed {
        logic               flush_valid;
        logic signed [63:0] int_value;
        logic               tok_valid;
        t_kind              tok_kind;
        logic [7:0]         tok_char;
    } t_entry;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Largest magnitude that can still take one more digit.
    localparam logic signed [63:0] ACC_HI = 64'sd922337203685477580;
    localparam logic signed [63:0] ACC_LO = -64'sd922337203685477580;

endpackage

// File: rtl/jts_front.sv
// Front end: accepts bytes, tracks lexer state and builds token entries.
module jts_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_char_code,
    input  logic                  i_full,
    output logic                  o_in_ready,
    output logic                  o_push,
    output jts_pkg::t_entry       o_entry
);

    logic               r_str;
    logic               r_int;
    logic               r_neg;
    logic signed [63:0] r_acc;
    logic               r_halted;

    logic               n_str;
    logic               n_int;
    logic               n_neg;
    logic signed [63:0] n_acc;
    logic               n_halted;

    logic               accept;
    logic [3:0]         digit;
    logic [63:0]        prod;
    logic [64:0]        sum;
    logic               ovf;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign digit      = i_char_code[3:0];
    assign prod       = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0};
    assign sum        = r_neg ? ({prod[63], prod} - {61'd0, digit})
                              : ({prod[63], prod} + {61'd0, digit});
    assign ovf        = (r_acc > jts_pkg::ACC_HI) || (r_acc < jts_pkg::ACC_LO)
                        || (sum[64] != sum[63]);

    always_comb begin
        n_str    = r_str;
        n_int    = r_int;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_halted = r_halted;
        o_entry  = '{flush_valid: 1'b0, int_value: 64'sd0, tok_valid: 1'b0,
                     tok_kind: jts_pkg::K_OBJ_BEGIN, tok_char: 8'd0};
        if (accept && !r_halted && i_char_code != jts_pkg::CH_NEWLINE) begin
            if (r_str) begin
                o_entry.tok_valid = 1'b1;
                if (i_char_code inside {jts_pkg::CH_DQUOTE, jts_pkg::CH_SQUOTE}) begin
                    n_str            = 1'b0;
                    o_entry.tok_kind = jts_pkg::K_STR_END;
                end else begin
                    o_entry.tok_kind = jts_pkg::K_STR_CHAR;
                    o_entry.tok_char = i_char_code;
                end
            end else if (i_char_code inside {jts_pkg::CH_DQUOTE, jts_pkg::CH_SQUOTE}) begin
                n_str = 1'b1;
            end else if (i_char_code inside {jts_pkg::CH_COLON, jts_pkg::CH_SPACE,
                                             jts_pkg::CH_COMMA, jts_pkg::CH_LBRACE,
                                             jts_pkg::CH_RBRACE, jts_pkg::CH_LBRACK,
                                             jts_pkg::CH_RBRACK}) begin
                if (r_int) begin
                    o_entry.flush_valid = 1'b1;
                    o_entry.int_value   = r_acc;
                    n_int               = 1'b0;
                    n_neg               = 1'b0;
                    n_acc               = 64'sd0;
                end
                o_entry.tok_valid = 1'b1;
                case (i_char_code)
                    jts_pkg::CH_LBRACE: o_entry.tok_kind = jts_pkg::K_OBJ_BEGIN;
                    jts_pkg::CH_RBRACE: o_entry.tok_kind = jts_pkg::K_OBJ_END;
                    jts_pkg::CH_LBRACK: o_entry.tok_kind = jts_pkg::K_LIST_BEGIN;
                    jts_pkg::CH_RBRACK: o_entry.tok_kind = jts_pkg::K_LIST_END;
                    default:            o_entry.tok_valid = 1'b0;
                endcase
            end else if (i_char_code == jts_pkg::CH_MINUS) begin
                n_neg = !r_neg;
            end else if (i_char_code inside {[jts_pkg::CH_ZERO:jts_pkg::CH_NINE]}) begin
                if (ovf) begin
                    n_halted          = 1'b1;
                    o_entry.tok_valid = 1'b1;
                    o_entry.tok_kind  = jts_pkg::K_OVERFLOW;
                end else begin
                    n_acc = sum[63:0];
                    n_int = 1'b1;
                end
            end else begin
                n_halted          = 1'b1;
                o_entry.tok_valid = 1'b1;
                o_entry.tok_kind  = jts_pkg::K_BAD_CHAR;
            end
        end
    end

    assign o_push = o_entry.flush_valid || o_entry.tok_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str    <= 1'b0;
            r_int    <= 1'b0;
            r_neg    <= 1'b0;
            r_acc    <= 64'sd0;
            r_halted <= 1'b0;
        end else begin
            r_str    <= n_str;
            r_int    <= n_int;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_halted <= n_halted;
        end
    end

endmodule

// File: rtl/jts_fifo.sv
// Short entry queue between the front and back ends.
module jts_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jts_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output jts_pkg::t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jts_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/jts_back.sv
// Back end: splits queue entries into token beats on the output register.
module jts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  jts_pkg::t_entry    i_head,
    input  logic               i_out_ready,
    output logic               o_pop,
    output logic               o_out_valid,
    output logic [3:0]         o_kind,
    output logic signed [63:0] o_int_value,
    output logic [7:0]         o_str_char,
    output logic               o_last
);

    logic               r_valid;
    logic               r_phase;
    jts_pkg::t_kind     r_kind;
    logic signed [63:0] r_int_value;
    logic [7:0]         r_str_char;
    logic               r_last;

    logic load;
    logic take_int;

    assign load     = (!r_valid || i_out_ready) && !i_empty;
    assign take_int = !r_phase && i_head.flush_valid;
    assign o_pop    = load && !(take_int && i_head.tok_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= take_int && i_head.tok_valid;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (take_int) begin
                r_kind      <= jts_pkg::K_INT;
                r_int_value <= i_head.int_value;
                r_str_char  <= 8'd0;
                r_last      <= !i_head.tok_valid;
            end else begin
                r_kind      <= i_head.tok_kind;
                r_int_value <= 64'sd0;
                r_str_char  <= i_head.tok_char;
                r_last      <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_int_value = r_int_value;
    assign o_str_char  = r_str_char;
    assign o_last      = r_last;

endmodule

// File: rtl/json_token_scanner.sv
// Top level of the JSON token scanner: front end, entry queue, back end.
// Takes one character byte per cycle on the input channel and emits JSON tokens
// (braces, brackets, integers, string characters, string end, errors) on the
// output channel, one token per cycle while the receiver is ready. A byte
// that flushes a pending integer and also yields a bracket or brace token
// gives two tokens, the integer first. The front end does all per-byte work
// combinationally, including the 64-bit digit accumulate-and-overflow check;
// a QUEUE_DEPTH-entry queue decouples it from the output register, so input
// stalls only when the queue is full. After a bad character or an integer
// overflow the block keeps accepting bytes but emits nothing until reset.
module json_token_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_kind,
    output logic signed [63:0] o_int_value,
    output logic [7:0]         o_str_char,
    output logic               o_last
);

    jts_pkg::t_entry entry;
    jts_pkg::t_entry head;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    jts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_char_code (i_char_code),
        .i_full      (full),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_entry     (entry)
    );

    jts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    jts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .i_out_ready (i_out_ready),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_int_value (o_int_value),
        .o_str_char  (o_str_char),
        .o_last      (o_last)
    );

endmodule

// File: dv/token_checker.sv
// Token checker for the JSON scanner: predicts tokens from accepted bytes, compares outputs.
`timescale 1ns / 100ps

module token_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [3:0]         i_kind,
    input  logic signed [63:0] i_int_value,
    input  logic [7:0]         i_str_char,
    input  logic               i_last,
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct {
        jts_pkg::t_kind     kind;
        logic signed [63:0] value;
        logic [7:0]         ch;
        logic               last;
    } t_token;

    localparam logic signed [63:0] INT_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] INT_BOT = 64'sh8000_0000_0000_0000;

    t_token             tokens_due[$];
    logic               in_str  = 1'b0;
    logic               in_int  = 1'b0;
    logic               neg     = 1'b0;
    logic               stopped = 1'b0;
    logic signed [63:0] acc     = '0;
    int                 fails   = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: token mismatch: %s", $time, what);
        fails++;
    endtask

    task automatic add_token(input jts_pkg::t_kind k, input logic signed [63:0] v,
                             input logic [7:0] c);
        t_token t;
        t.kind  = k;
        t.value = v;
        t.ch    = c;
        t.last  = 1'b0;
        tokens_due = {tokens_due, t};
    endtask

    task automatic flush_number();
        if (in_int) begin
            add_token(jts_pkg::K_INT, acc, 8'h00);
            in_int = 1'b0;
            neg    = 1'b0;
            acc    = '0;
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        int                 start_n;
        logic signed [63:0] d;
        logic signed [63:0] p;
        logic               ovf;
        start_n = tokens_due.size();
        if (stopped || c == jts_pkg::CH_NEWLINE) begin
            // nothing
        end else if (in_str) begin
            if (c == jts_pkg::CH_DQUOTE || c == jts_pkg::CH_SQUOTE) begin
                in_str = 1'b0;
                add_token(jts_pkg::K_STR_END, '0, 8'h00);
            end else begin
                add_token(jts_pkg::K_STR_CHAR, '0, c);
            end
        end else if (c == jts_pkg::CH_DQUOTE || c == jts_pkg::CH_SQUOTE) begin
            in_str = 1'b1;
        end else if (c == jts_pkg::CH_COLON || c == jts_pkg::CH_SPACE ||
                     c == jts_pkg::CH_COMMA) begin
            flush_number();
        end else if (c == jts_pkg::CH_LBRACE || c == jts_pkg::CH_RBRACE ||
                     c == jts_pkg::CH_LBRACK || c == jts_pkg::CH_RBRACK) begin
            flush_number();
            add_token(c == jts_pkg::CH_LBRACE ? jts_pkg::K_OBJ_BEGIN :
                      c == jts_pkg::CH_RBRACE ? jts_pkg::K_OBJ_END   :
                      c == jts_pkg::CH_LBRACK ? jts_pkg::K_LIST_BEGIN :
                                                jts_pkg::K_LIST_END, '0, 8'h00);
        end else if (c == jts_pkg::CH_MINUS) begin
            neg = !neg;
        end else if (c >= jts_pkg::CH_ZERO && c <= jts_pkg::CH_NINE) begin
            d   = $signed({56'd0, c - jts_pkg::CH_ZERO});
            p   = '0;
            ovf = 1'b0;
            if (acc > INT_TOP / 64'sd10 || acc < INT_BOT / 64'sd10) begin
                ovf = 1'b1;
            end else begin
                p = acc * 64'sd10;
                if (neg) begin
                    ovf = p < INT_BOT + d;
                end else begin
                    ovf = p > INT_TOP - d;
                end
            end
            if (ovf) begin
                stopped = 1'b1;
                add_token(jts_pkg::K_OVERFLOW, '0, 8'h00);
            end else begin
                acc    = neg ? p - d : p + d;
                in_int = 1'b1;
            end
        end else begin
            stopped = 1'b1;
            add_token(jts_pkg::K_BAD_CHAR, '0, 8'h00);
        end
        if (tokens_due.size() > start_n) begin
            tokens_due[tokens_due.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_token();
        t_token t;
        if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("token kind %0d with none expected", i_kind));
        end else begin
            t = tokens_due.pop_front();
            if (i_kind !== t.kind) begin
                report_mismatch($sformatf("kind %0d, expected %0d", i_kind, t.kind));
            end
            if (i_int_value !== t.value) begin
                report_mismatch($sformatf("int_value %0d, expected %0d", i_int_value, t.value));
            end
            if (i_str_char !== t.ch) begin
                report_mismatch($sformatf("str_char %02h, expected %02h", i_str_char, t.ch));
            end
            if (i_last !== t.last) begin
                report_mismatch($sformatf("last %0b, expected %0b", i_last, t.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_str  = 1'b0;
            in_int  = 1'b0;
            neg     = 1'b0;
            stopped = 1'b0;
            acc     = '0;
            tokens_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                scan_char(i_char_code);
            end
            if (i_out_valid && i_out_ready) begin
                check_token();
            end
        end
        o_pending    <= tokens_due.size();
        o_fail_count <= fails;
    end

endmodule

// File: dv/testbench.sv
// Top of the JSON scanner testbench: clock, reset, byte stimulus, receiver and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [7:0]  ENDERS[7] = '{jts_pkg::CH_SPACE, jts_pkg::CH_COLON,
                                          jts_pkg::CH_COMMA, jts_pkg::CH_LBRACK,
                                          jts_pkg::CH_RBRACK, jts_pkg::CH_LBRACE,
                                          jts_pkg::CH_RBRACE};
    localparam logic [7:0]  BRACKETS[4] = '{jts_pkg::CH_LBRACK, jts_pkg::CH_RBRACK,
                                            jts_pkg::CH_LBRACE, jts_pkg::CH_RBRACE};
    localparam logic [7:0]  NOISE[5] = '{jts_pkg::CH_SPACE, jts_pkg::CH_COLON,
                                         jts_pkg::CH_COMMA, jts_pkg::CH_NEWLINE,
                                         jts_pkg::CH_MINUS};
    localparam int          HOLD_CYCLES = 200;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_char_code = 8'h00;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [3:0]         o_kind;
    logic signed [63:0] o_int_value;
    logic [7:0]         o_str_char;
    logic               o_last;

    int   pending;
    int   fail_count;
    int   sent_count = 0;
    logic no_idle    = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;

    always #5 i_clk = ~i_clk;

    json_token_scanner uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_int_value (o_int_value),
        .o_str_char  (o_str_char),
        .o_last      (o_last)
    );

    token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_kind       (o_kind),
        .i_int_value  (o_int_value),
        .i_str_char   (o_str_char),
        .i_last       (o_last),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    task automatic send_char(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_char(jts_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic send_decimal(input logic [63:0] mag);
        logic [7:0] digs[$];
        do begin
            digs.push_front(jts_pkg::CH_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 0);
        foreach (digs[i]) send_char(digs[i]);
    endtask

    task automatic send_quote();
        send_char($urandom_range(1) ? jts_pkg::CH_DQUOTE : jts_pkg::CH_SQUOTE);
    endtask

    task automatic send_string();
        logic [7:0] b;
        send_quote();
        repeat ($urandom_range(6)) begin
            do b = 8'($urandom_range(255));
            while (b == jts_pkg::CH_DQUOTE || b == jts_pkg::CH_SQUOTE);
            send_char(b);
        end
        send_quote();
    endtask

    // short numbers with stray signs, mid-number signs and strings inside the number
    task automatic send_small_int();
        int shape;
        shape = $urandom_range(3);
        repeat ($urandom_range(2)) send_char(jts_pkg::CH_MINUS);
        send_digits($urandom_range(6, 1));
        if (shape == 1) begin
            send_string();
            send_digits($urandom_range(6));
        end else if (shape == 2) begin
            send_char(jts_pkg::CH_MINUS);
            send_digits($urandom_range(6, 1));
        end
        send_char(ENDERS[$urandom_range(6)]);
    endtask

    // "0 " first flushes to a clean sign so full-width values stay in range
    task automatic send_big_int(input logic minus, input logic [63:0] mag);
        send_char(jts_pkg::CH_ZERO);
        send_char(jts_pkg::CH_SPACE);
        if (minus) begin
            send_char(jts_pkg::CH_MINUS);
        end
        send_decimal(mag);
        send_char(ENDERS[$urandom_range(6)]);
    endtask

    task automatic send_random_big();
        logic        minus;
        logic [63:0] mag;
        minus = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: mag = minus ? NEG_LIMIT : POS_LIMIT;
            1: mag = (minus ? NEG_LIMIT : POS_LIMIT) - 64'($urandom_range(999));
            2: mag = {1'b0, 31'($urandom), 32'($urandom)};
            default: mag = 64'($urandom_range(999999999));
        endcase
        send_big_int(minus, mag);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_halt();
        logic [7:0] b;
        logic       minus;
        minus = 1'($urandom_range(1));
        case ($urandom_range(2))
            0: begin
                do b = 8'($urandom_range(255));
                while (b inside {jts_pkg::CH_NEWLINE, jts_pkg::CH_DQUOTE, jts_pkg::CH_SQUOTE,
                                 jts_pkg::CH_COLON, jts_pkg::CH_SPACE, jts_pkg::CH_COMMA,
                                 jts_pkg::CH_LBRACE, jts_pkg::CH_RBRACE, jts_pkg::CH_LBRACK,
                                 jts_pkg::CH_RBRACK, jts_pkg::CH_MINUS,
                                 [jts_pkg::CH_ZERO:jts_pkg::CH_NINE]});
                send_char(b);
            end
            1: begin
                send_char(jts_pkg::CH_ZERO);
                send_char(jts_pkg::CH_SPACE);
                if (minus) begin
                    send_char(jts_pkg::CH_MINUS);
                end
                send_decimal(NEG_LIMIT + 64'(minus) + 64'($urandom_range(1000)));
            end
            default: begin
                send_char(jts_pkg::CH_ZERO);
                send_char(jts_pkg::CH_SPACE);
                if (minus) begin
                    send_char(jts_pkg::CH_MINUS);
                end
                send_char(jts_pkg::CH_ZERO + 8'd1);
                send_digits(20);
            end
        endcase
    endtask

    initial begin
        int sel;
        logic paused;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("{\"k\n':[12'x'3,5-3 -,7:--8]\n}");
        send_big_int(1'b0, POS_LIMIT);
        send_big_int(1'b1, NEG_LIMIT);

        while (sent_count < 470) begin
            if (!hold_req && sent_count >= 150) begin
                hold_req <= 1'b1;
            end
            if (!paused && sent_count >= 300) begin
                paused = 1'b1;
                i_in_valid <= 1'b0;
                wait_drained();
            end
            no_idle <= (sent_count >= 350 && sent_count < 450);
            sel = $urandom_range(99);
            if (sel < 30) begin
                send_string();
            end else if (sel < 60) begin
                send_small_int();
            end else if (sel < 68) begin
                send_random_big();
            end else if (sel < 85) begin
                send_char(BRACKETS[$urandom_range(3)]);
            end else begin
                send_char(NOISE[$urandom_range(4)]);
            end
        end

        // block halts here; later bytes must yield nothing
        send_halt();
        repeat (12) send_char(8'($urandom_range(255)));
        i_in_valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
